// ===== rtl/ausm_pkg.sv =====
// Package for the AUSM flux splitting unit.
// Holds the default number format and the multiplier latency used by the flux splitting unit.
package ausm_pkg;

  // Default fixed-point format: signed Q31.16 in 48-bit words.
  localparam int FRAC_BITS   = 16;
  localparam int VALUE_WIDTH = 48;

  // Register stages in one saturating fixed-point multiplier.
  localparam int MUL_LATENCY = 3;

endpackage

// ===== rtl/ausm_if.sv =====
// Valid/ready channel interfaces of the AUSM flux splitting unit.
// Width follows VALUE_WIDTH; depends on ausm_pkg for its default.
interface ausm_in_if #(
  parameter int VALUE_WIDTH = ausm_pkg::VALUE_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] vel_left;
  logic        [VALUE_WIDTH-2:0] sound_left;
  logic        [VALUE_WIDTH-2:0] dens_left;
  logic        [VALUE_WIDTH-2:0] pres_left;
  logic signed [VALUE_WIDTH-1:0] vel_right;
  logic        [VALUE_WIDTH-2:0] sound_right;
  logic        [VALUE_WIDTH-2:0] dens_right;
  logic        [VALUE_WIDTH-2:0] pres_right;

  modport source (
    output valid, vel_left, sound_left, dens_left, pres_left,
    output vel_right, sound_right, dens_right, pres_right,
    input  ready
  );
  modport sink (
    input  valid, vel_left, sound_left, dens_left, pres_left,
    input  vel_right, sound_right, dens_right, pres_right,
    output ready
  );
endinterface

interface ausm_out_if #(
  parameter int VALUE_WIDTH = ausm_pkg::VALUE_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] mass_flux;
  logic signed [VALUE_WIDTH-1:0] interface_pressure;
  logic                          upwind_right;
  logic                          div_fault;

  modport source (
    output valid, mass_flux, interface_pressure, upwind_right, div_fault,
    input  ready
  );
  modport sink (
    input  valid, mass_flux, interface_pressure, upwind_right, div_fault,
    output ready
  );
endinterface

// ===== rtl/ausm_mul.sv =====
// Three-stage saturating fixed-point multiplier of the AUSM unit.
// Splits the magnitudes into halves so that at the default width no partial product exceeds 24x24 bits.
module ausm_mul #(
  parameter int VALUE_WIDTH = ausm_pkg::VALUE_WIDTH,
  parameter int SHIFT       = ausm_pkg::FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [VALUE_WIDTH-1:0] a,
  input  logic signed [VALUE_WIDTH-1:0] b,
  output logic signed [VALUE_WIDTH-1:0] p
);
  localparam int W  = VALUE_WIDTH;
  localparam int H  = (W + 1) / 2;
  localparam int PW = 4 * H;

  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

  logic [2*H-1:0] am_r, bm_r;
  logic           neg1_r, neg2_r;
  logic [2*H-1:0] pll_r, plh_r, phl_r, phh_r;
  logic [W-1:0]   p_r;

  logic [W-1:0]    am_nxt, bm_nxt;
  logic [PW-1:0]   sum;
  logic [PW-1:0]   shifted;
  logic            big;
  logic [W-1:0]    p_nxt;

  // Stage one: signs and magnitudes.
  always_comb begin
    am_nxt = a[W-1] ? W'(-a) : W'(a);
    bm_nxt = b[W-1] ? W'(-b) : W'(b);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= a[W-1] ^ b[W-1];
      am_r   <= (2*H)'(am_nxt);
      bm_r   <= (2*H)'(bm_nxt);
    end
  end

  // Stage two: four half-width partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      neg2_r <= neg1_r;
      pll_r  <= am_r[H-1:0]     * bm_r[H-1:0];
      plh_r  <= am_r[H-1:0]     * bm_r[2*H-1:H];
      phl_r  <= am_r[2*H-1:H]   * bm_r[H-1:0];
      phh_r  <= am_r[2*H-1:H]   * bm_r[2*H-1:H];
    end
  end

  // Stage three: sum, scale, saturate and restore the sign.
  always_comb begin
    sum = PW'(pll_r) + (PW'(plh_r) << H) + (PW'(phl_r) << H) + (PW'(phh_r) << (2*H));
    shifted = sum >> SHIFT;
    big = |shifted[PW-1:W-1];
    if (neg2_r) begin
      p_nxt = big ? MIN_NEG : W'(-{1'b0, shifted[W-2:0]});
    end else begin
      p_nxt = big ? MAX_POS : {1'b0, shifted[W-2:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

// ===== rtl/ausm_flux_splitting_unit.sv =====
// AUSM flux splitting at one cell face, fully pipelined.
// Depends on ausm_pkg, the channel interfaces in ausm_if.sv and ausm_mul.
//
//   channel  direction  handshake           payload
//   in_ch    sink       valid/ready         left and right u, a, rho, p
//   out_ch   source     valid/ready         mass flux, pressure, side, fault
//
// One face enters per cycle unless held; it passes the input stage, two bit-per-stage
// Mach dividers, the Mach stage, three multiplier ranks and the output register.
// rst_n clears only the valid bits; data registers carry no reset.
// When the output register is full and not taken, the whole pipeline holds.
module ausm_flux_splitting_unit #(
  parameter int FRAC_BITS   = ausm_pkg::FRAC_BITS,
  parameter int VALUE_WIDTH = ausm_pkg::VALUE_WIDTH
) (
  input logic       clk,
  input logic       rst_n,
  ausm_in_if.sink   in_ch,
  ausm_out_if.source out_ch
);
  localparam int W   = VALUE_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int N   = W + F;
  localparam int ML  = ausm_pkg::MUL_LATENCY;
  localparam int LAT = N + 3 * ML + 3;

  localparam logic signed [W-1:0] ONE     = W'(1) << F;
  localparam logic signed [W-1:0] TWO     = W'(2) << F;
  localparam logic signed [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic [W-2:0] al;
    logic [W-2:0] ar;
    logic [W-2:0] rl;
    logic [W-2:0] rr;
    logic [W-2:0] pl;
    logic [W-2:0] pr;
    logic         fault;
  } side_t;

  typedef struct packed {
    logic signed [W-1:0] ml;
    logic signed [W-1:0] mr;
    logic                subl;
    logic                subr;
    side_t               side;
  } seg1_t;

  typedef struct packed {
    logic  subl;
    logic  subr;
    logic  mlpos;
    logic  mrneg;
    logic  right;
    side_t side;
  } seg2_t;

  typedef struct packed {
    logic right;
    logic fault;
  } seg3_t;

  logic en;
  logic [LAT-1:0] vld_r;

  // Global advance: the pipeline moves unless a held result is not taken.
  assign en = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  // Input stage: velocity magnitudes and the fault flag.
  side_t        s0_side_r;
  logic         s0_negl_r, s0_negr_r;
  logic [W-1:0] s0_magl_r, s0_magr_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_side_r.al    <= in_ch.sound_left;
      s0_side_r.ar    <= in_ch.sound_right;
      s0_side_r.rl    <= in_ch.dens_left;
      s0_side_r.rr    <= in_ch.dens_right;
      s0_side_r.pl    <= in_ch.pres_left;
      s0_side_r.pr    <= in_ch.pres_right;
      s0_side_r.fault <= (in_ch.sound_left == '0) || (in_ch.sound_right == '0);
      s0_negl_r       <= in_ch.vel_left[W-1];
      s0_negr_r       <= in_ch.vel_right[W-1];
      s0_magl_r       <= in_ch.vel_left[W-1]  ? W'(-in_ch.vel_left)  : W'(in_ch.vel_left);
      s0_magr_r       <= in_ch.vel_right[W-1] ? W'(-in_ch.vel_right) : W'(in_ch.vel_right);
    end
  end

  // Mach dividers: one restoring quotient bit per stage for each side.
  logic [W-2:0] dv_reml [0:N];
  logic [W-2:0] dv_remr [0:N];
  logic [N-1:0] dv_numl [0:N];
  logic [N-1:0] dv_numr [0:N];
  logic [N-1:0] dv_ql   [0:N];
  logic [N-1:0] dv_qr   [0:N];
  logic         dv_negl [0:N];
  logic         dv_negr [0:N];
  side_t        dv_side [0:N];

  assign dv_reml[0] = '0;
  assign dv_remr[0] = '0;
  assign dv_numl[0] = {s0_magl_r, {F{1'b0}}};
  assign dv_numr[0] = {s0_magr_r, {F{1'b0}}};
  assign dv_ql[0]   = '0;
  assign dv_qr[0]   = '0;
  assign dv_negl[0] = s0_negl_r;
  assign dv_negr[0] = s0_negr_r;
  assign dv_side[0] = s0_side_r;

  for (genvar k = 0; k < N; k++) begin : g_div
    logic [W-1:0] triall, trialr;
    logic         gel, ger;
    logic [W-2:0] reml_r, remr_r;
    logic [N-1:0] numl_r, numr_r, ql_r, qr_r;
    logic         negl_r, negr_r;
    side_t        side_r;

    // Shift in the next numerator bit and subtract the divisor if it fits.
    always_comb begin
      triall = {dv_reml[k], dv_numl[k][N-1-k]};
      trialr = {dv_remr[k], dv_numr[k][N-1-k]};
      gel    = triall >= {1'b0, dv_side[k].al};
      ger    = trialr >= {1'b0, dv_side[k].ar};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        reml_r <= gel ? (W-1)'(triall - {1'b0, dv_side[k].al}) : triall[W-2:0];
        remr_r <= ger ? (W-1)'(trialr - {1'b0, dv_side[k].ar}) : trialr[W-2:0];
        ql_r   <= {dv_ql[k][N-2:0], gel};
        qr_r   <= {dv_qr[k][N-2:0], ger};
        numl_r <= dv_numl[k];
        numr_r <= dv_numr[k];
        negl_r <= dv_negl[k];
        negr_r <= dv_negr[k];
        side_r <= dv_side[k];
      end
    end

    assign dv_reml[k+1] = reml_r;
    assign dv_remr[k+1] = remr_r;
    assign dv_ql[k+1]   = ql_r;
    assign dv_qr[k+1]   = qr_r;
    assign dv_numl[k+1] = numl_r;
    assign dv_numr[k+1] = numr_r;
    assign dv_negl[k+1] = negl_r;
    assign dv_negr[k+1] = negr_r;
    assign dv_side[k+1] = side_r;
  end

  // Mach stage: saturate the quotients, apply signs, classify subsonic.
  seg1_t mc_nxt;
  seg1_t mc_r;
  logic  bigl, bigr;

  always_comb begin
    bigl = |dv_ql[N][N-1:W-1];
    bigr = |dv_qr[N][N-1:W-1];
    mc_nxt.side = dv_side[N];
    mc_nxt.subl = !bigl && ({1'b0, dv_ql[N][W-2:0]} <= ONE);
    mc_nxt.subr = !bigr && ({1'b0, dv_qr[N][W-2:0]} <= ONE);
    if (dv_negl[N]) begin
      mc_nxt.ml = bigl ? MIN_NEG : W'(-{1'b0, dv_ql[N][W-2:0]});
    end else begin
      mc_nxt.ml = bigl ? MAX_POS : {1'b0, dv_ql[N][W-2:0]};
    end
    if (dv_negr[N]) begin
      mc_nxt.mr = bigr ? MIN_NEG : W'(-{1'b0, dv_qr[N][W-2:0]});
    end else begin
      mc_nxt.mr = bigr ? MAX_POS : {1'b0, dv_qr[N][W-2:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mc_r <= mc_nxt;
    end
  end

  // First multiplier rank: the squares (M+1)^2/4 and (M-1)^2/4.
  logic signed [W-1:0] tl, tr, sql, sqr;
  assign tl = W'(mc_r.ml + ONE);
  assign tr = W'(mc_r.mr - ONE);

  ausm_mul #(.VALUE_WIDTH(W), .SHIFT(F + 2)) u_mul_sql (
    .clk(clk), .en(en), .a(tl), .b(tl), .p(sql)
  );
  ausm_mul #(.VALUE_WIDTH(W), .SHIFT(F + 2)) u_mul_sqr (
    .clk(clk), .en(en), .a(tr), .b(tr), .p(sqr)
  );

  seg1_t d1_r [1:ML];
  always_ff @(posedge clk) begin
    if (en) begin
      d1_r[1] <= mc_r;
      for (int i = 2; i <= ML; i++) begin
        d1_r[i] <= d1_r[i-1];
      end
    end
  end

  // Split Mach numbers, combined Mach and second multiplier rank.
  seg1_t               a1;
  seg2_t               s2_nxt;
  logic signed [W-1:0] mp, mm, mcomb, fpl, fpr, asel;

  always_comb begin
    a1    = d1_r[ML];
    mp    = a1.subl ? sql : (a1.ml > 0 ? a1.ml : '0);
    mm    = a1.subr ? W'(-sqr) : (a1.mr < 0 ? a1.mr : '0);
    mcomb = W'(mp + mm);
    fpl   = W'(TWO - a1.ml);
    fpr   = W'(TWO + a1.mr);
    s2_nxt.subl  = a1.subl;
    s2_nxt.subr  = a1.subr;
    s2_nxt.mlpos = a1.ml > 0;
    s2_nxt.mrneg = a1.mr < 0;
    s2_nxt.right = mcomb < 0;
    s2_nxt.side  = a1.side;
    asel  = s2_nxt.right ? {1'b0, a1.side.ar} : {1'b0, a1.side.al};
  end

  logic signed [W-1:0] ppm, pmm, fma;

  ausm_mul #(.VALUE_WIDTH(W), .SHIFT(F)) u_mul_pp (
    .clk(clk), .en(en), .a(mp), .b(fpl), .p(ppm)
  );
  ausm_mul #(.VALUE_WIDTH(W), .SHIFT(F)) u_mul_pm (
    .clk(clk), .en(en), .a(sqr), .b(fpr), .p(pmm)
  );
  ausm_mul #(.VALUE_WIDTH(W), .SHIFT(F)) u_mul_ma (
    .clk(clk), .en(en), .a(mcomb), .b(asel), .p(fma)
  );

  seg2_t d2_r [1:ML];
  always_ff @(posedge clk) begin
    if (en) begin
      d2_r[1] <= s2_nxt;
      for (int i = 2; i <= ML; i++) begin
        d2_r[i] <= d2_r[i-1];
      end
    end
  end

  // Pressure weights and third multiplier rank.
  seg2_t               a2;
  seg3_t               s3_nxt;
  logic signed [W-1:0] ppw, pmw, rsel, pl_w, pr_w;

  always_comb begin
    a2   = d2_r[ML];
    ppw  = a2.subl ? ppm : (a2.mlpos ? ONE : '0);
    pmw  = a2.subr ? pmm : (a2.mrneg ? ONE : '0);
    rsel = a2.right ? {1'b0, a2.side.rr} : {1'b0, a2.side.rl};
    pl_w = {1'b0, a2.side.pl};
    pr_w = {1'b0, a2.side.pr};
    s3_nxt.right = a2.right;
    s3_nxt.fault = a2.side.fault;
  end

  logic signed [W-1:0] pld, prd, flux;

  ausm_mul #(.VALUE_WIDTH(W), .SHIFT(F)) u_mul_pl (
    .clk(clk), .en(en), .a(pl_w), .b(ppw), .p(pld)
  );
  ausm_mul #(.VALUE_WIDTH(W), .SHIFT(F)) u_mul_pr (
    .clk(clk), .en(en), .a(pr_w), .b(pmw), .p(prd)
  );
  ausm_mul #(.VALUE_WIDTH(W), .SHIFT(F)) u_mul_fx (
    .clk(clk), .en(en), .a(fma), .b(rsel), .p(flux)
  );

  seg3_t d3_r [1:ML];
  always_ff @(posedge clk) begin
    if (en) begin
      d3_r[1] <= s3_nxt;
      for (int i = 2; i <= ML; i++) begin
        d3_r[i] <= d3_r[i-1];
      end
    end
  end

  // Output register: pressure sum with saturation, fault forces zeros.
  logic [W:0]          psum;
  logic signed [W-1:0] pres_nxt;
  logic signed [W-1:0] flux_r, pres_r;
  logic                right_r, fault_r;

  always_comb begin
    psum     = {1'b0, pld} + {1'b0, prd};
    pres_nxt = psum[W-1] ? MAX_POS : psum[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fault_r <= d3_r[ML].fault;
      flux_r  <= d3_r[ML].fault ? '0 : flux;
      pres_r  <= d3_r[ML].fault ? '0 : pres_nxt;
      right_r <= d3_r[ML].fault ? 1'b0 : d3_r[ML].right;
    end
  end

  assign out_ch.valid              = vld_r[LAT-1];
  assign out_ch.mass_flux          = flux_r;
  assign out_ch.interface_pressure = pres_r;
  assign out_ch.upwind_right       = right_r;
  assign out_ch.div_fault          = fault_r;

endmodule
